/* rtl/ecomp_pkg.sv */
// Shared types, constants and helper functions of the sensor compensation block.
package ecomp_pkg;

    localparam int CFG_DATA_W  = 64;
    localparam int CFG_INDEX_W = 3;

    localparam logic [CFG_INDEX_W-1:0] CFG_TEMP_CAL    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PRESS_CAL_A = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PRESS_CAL_B = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PRESS_CAL_C = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_HUMID_CAL   = 3'd4;

    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] STEP_T_A     = 5'd0;
    localparam logic [STEP_W-1:0] STEP_T_SQ    = 5'd1;
    localparam logic [STEP_W-1:0] STEP_T_FINE  = 5'd2;
    localparam logic [STEP_W-1:0] STEP_H_A     = 5'd3;
    localparam logic [STEP_W-1:0] STEP_H_B     = 5'd4;
    localparam logic [STEP_W-1:0] STEP_H_C     = 5'd5;
    localparam logic [STEP_W-1:0] STEP_H_D     = 5'd6;
    localparam logic [STEP_W-1:0] STEP_H_E     = 5'd7;
    localparam logic [STEP_W-1:0] STEP_H_V     = 5'd8;
    localparam logic [STEP_W-1:0] STEP_H_SQ    = 5'd9;
    localparam logic [STEP_W-1:0] STEP_H_FIX   = 5'd10;
    localparam logic [STEP_W-1:0] STEP_P_SQ    = 5'd11;
    localparam logic [STEP_W-1:0] STEP_P_V2A   = 5'd12;
    localparam logic [STEP_W-1:0] STEP_P_V2B   = 5'd13;
    localparam logic [STEP_W-1:0] STEP_P_V1A   = 5'd14;
    localparam logic [STEP_W-1:0] STEP_P_V1B   = 5'd15;
    localparam logic [STEP_W-1:0] STEP_P_DEN   = 5'd16;
    localparam logic [STEP_W-1:0] STEP_P_NUM   = 5'd17;
    localparam logic [STEP_W-1:0] STEP_P_Q1A   = 5'd18;
    localparam logic [STEP_W-1:0] STEP_P_Q1B   = 5'd19;
    localparam logic [STEP_W-1:0] STEP_P_Q2    = 5'd20;

    localparam logic [31:0] HUM_LIMIT = 32'd419430400;

    typedef struct packed {
        logic [19:0] raw_temperature;
        logic [19:0] raw_pressure;
        logic [15:0] raw_humidity;
    } sample_t;

    typedef struct packed {
        logic signed [31:0] temperature;
        logic [31:0]        pressure;
        logic               pressure_ok;
        logic [16:0]        humidity;
    } result_t;

    typedef struct packed {
        logic [47:0] temp_cal;
        logic [63:0] press_cal_a;
        logic [63:0] press_cal_b;
        logic [15:0] press_cal_c;
        logic [63:0] humid_cal;
    } cal_t;

    function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned n);
        asr32 = 32'($signed(x) >>> n);
    endfunction

    function automatic logic [63:0] asr64(input logic [63:0] x, input int unsigned n);
        asr64 = 64'($signed(x) >>> n);
    endfunction

    function automatic logic [63:0] sx32(input logic [31:0] x);
        sx32 = {{32{x[31]}}, x};
    endfunction

    function automatic logic [63:0] sx16(input logic [15:0] x);
        sx16 = {{48{x[15]}}, x};
    endfunction

endpackage

/* rtl/env_sensor_compensation_top.sv */
// Top level of the sensor compensation block: configuration registers, front queue, engine.
//
// Usage: raw readings enter as one word on the sample channel (sample_valid /
// sample_ready) and the compensated word leaves on the result channel
// (result_valid / result_ready), both plain valid/ready handshakes. Calibration
// words are to be written through cfg_we, cfg_index and cfg_data while the block
// is idle, which the block itself does not enforce; a write takes effect at the
// clock edge where cfg_we is high. Each word passes through the queue, the
// engine's accept step, 21 products on the shared multiplier, the one-bit-per-cycle
// divider for the pressure quotient and the output step. When the pressure
// divisor is zero the divide and the remaining pressure steps are skipped.
// Throughput is one word per engine pass. A two-word queue in front lets the
// sender hand over the next words while one is in work, and the result register
// lets the engine start a new word while a finished one still waits. If the
// receiver stalls, the result stays in the output register, the engine stops
// when it has its next result ready, and the queue then fills and drops
// sample_ready.
// Reset clears the calibration registers to zero and empties the queue and engine.
module env_sensor_compensation_top
    import ecomp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   sample_valid,
    output logic                   sample_ready,
    input  sample_t                sample,
    output logic                   result_valid,
    input  logic                   result_ready,
    output result_t                result,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cal_t    cal_reg, cal_next;
    logic    q_valid, q_ready;
    sample_t q_word;

    // Register write decode; indexes beyond the list are ignored.
    always_comb
    begin
        cal_next = cal_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_TEMP_CAL:    cal_next.temp_cal    = cfg_data[47:0];
                CFG_PRESS_CAL_A: cal_next.press_cal_a = cfg_data;
                CFG_PRESS_CAL_B: cal_next.press_cal_b = cfg_data;
                CFG_PRESS_CAL_C: cal_next.press_cal_c = cfg_data[15:0];
                CFG_HUMID_CAL:   cal_next.humid_cal   = cfg_data;
                default:         cal_next = cal_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_reg <= '0;
        end
        else
        begin
            cal_reg <= cal_next;
        end
    end

    ecomp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample_valid),
        .in_ready  (sample_ready),
        .in_word   (sample),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_word  (q_word)
    );

    ecomp_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cal       (cal_reg),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_word   (q_word),
        .out_valid (result_valid),
        .out_ready (result_ready),
        .out_word  (result)
    );

endmodule

/* rtl/ecomp_front.sv */
// Front end: two-entry queue that takes raw sample words ahead of the compute engine.
module ecomp_front
    import ecomp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  sample_t in_word,
    output logic    out_valid,
    input  logic    out_ready,
    output sample_t out_word
);

    sample_t     slot_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        push, pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_word  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_word;
        end
    end

endmodule

/* rtl/ecomp_mul.sv */
// Shared multiplier: low 64 bits of a 64 by 64 product from three 32 by 32 partials.
module ecomp_mul
    import ecomp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic        done,
    output logic [63:0] p
);

    logic [1:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [63:0] prod_reg, prod_next;
    logic [63:0] acc_reg, acc_next;
    logic [31:0] ma, mb;

    assign done = done_reg;
    assign p    = acc_reg;

    always_comb
    begin
        ma = a[31:0];
        mb = b[31:0];
        if (busy_reg && cnt_reg == 2'd1)
        begin
            mb = b[63:32];
        end
        else if (busy_reg && cnt_reg == 2'd2)
        begin
            ma = a[63:32];
        end
    end

    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        prod_next = prod_reg;
        acc_next  = acc_reg;
        if (!busy_reg)
        begin
            if (start)
            begin
                prod_next = ma * mb;
                busy_next = 1'b1;
                cnt_next  = 2'd1;
            end
        end
        else
        begin
            case (cnt_reg)
                2'd1:
                begin
                    acc_next  = prod_reg;
                    prod_next = ma * mb;
                    cnt_next  = 2'd2;
                end
                2'd2:
                begin
                    acc_next  = acc_reg + {prod_reg[31:0], 32'b0};
                    prod_next = ma * mb;
                    cnt_next  = 2'd3;
                end
                default:
                begin
                    acc_next  = acc_reg + {prod_reg[31:0], 32'b0};
                    busy_next = 1'b0;
                    done_next = 1'b1;
                    cnt_next  = 2'd0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 2'd0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

endmodule

/* rtl/ecomp_div.sv */
// Signed 64-bit divider, truncating, one quotient bit per cycle.
module ecomp_div
    import ecomp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] num,
    input  logic [63:0] den,
    output logic        done,
    output logic [63:0] quo
);

    logic [6:0]  cnt_reg, cnt_next;
    logic        done_reg, done_next;
    logic        neg_reg, neg_next;
    logic [63:0] q_reg, q_next;
    logic [63:0] rem_reg, rem_next;
    logic [63:0] dmag_reg, dmag_next;
    logic [64:0] shifted;

    assign done    = done_reg;
    assign quo     = neg_reg ? (64'd0 - q_reg) : q_reg;
    assign shifted = {rem_reg, q_reg[63]};

    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        dmag_next = dmag_reg;
        if (cnt_reg == 7'd0)
        begin
            if (start)
            begin
                neg_next  = num[63] ^ den[63];
                q_next    = num[63] ? (64'd0 - num) : num;
                dmag_next = den[63] ? (64'd0 - den) : den;
                rem_next  = 64'd0;
                cnt_next  = 7'd64;
            end
        end
        else
        begin
            if (shifted >= {1'b0, dmag_reg})
            begin
                rem_next = 64'(shifted - {1'b0, dmag_reg});
                q_next   = {q_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[63:0];
                q_next   = {q_reg[62:0], 1'b0};
            end
            cnt_next  = cnt_reg - 7'd1;
            done_next = (cnt_reg == 7'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 7'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg  <= neg_next;
        q_reg    <= q_next;
        rem_reg  <= rem_next;
        dmag_reg <= dmag_next;
    end

endmodule

/* rtl/ecomp_core.sv */
// Compute engine: step sequencer over the shared multiplier and divider, with result register.
module ecomp_core
    import ecomp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cal_t    cal,
    input  logic    in_valid,
    output logic    in_ready,
    input  sample_t in_word,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_word
);

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_MUL  = 4'b0010,
        PH_DIV  = 4'b0100,
        PH_OUT  = 4'b1000
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              issue_reg, issue_next;
    logic              res_valid_reg, res_valid_next;
    result_t           res_reg, res_next;
    sample_t           smp_reg;

    logic [31:0] a_reg, sq32_reg, tf_reg, x_reg, ha_reg, hb_reg, hc_reg;
    logic [31:0] hd_reg, he_reg, hv_reg, ht_reg;
    logic [63:0] v1_reg, sq_reg, v2_reg, w_reg, den_reg, r_reg, q_reg, q1_reg, sum_reg;
    logic        ok_reg;

    logic        mul_start, mul_done, div_start, div_done;
    logic [63:0] mul_a, mul_b, mul_p, div_q;
    logic [31:0] lo, tf_new, hs, hum32, t1, t2, t3, h1, h2, h3, h4, h5, h6;
    logic [63:0] rs, num_pre, den_new, rfin;
    logic        load_out;

    // Calibration word unpacking.
    assign t1 = {16'b0, cal.temp_cal[15:0]};
    assign t2 = {{16{cal.temp_cal[31]}}, cal.temp_cal[31:16]};
    assign t3 = {{16{cal.temp_cal[47]}}, cal.temp_cal[47:32]};
    assign h1 = {24'b0, cal.humid_cal[7:0]};
    assign h2 = {{16{cal.humid_cal[23]}}, cal.humid_cal[23:8]};
    assign h3 = {24'b0, cal.humid_cal[31:24]};
    assign h4 = {{20{cal.humid_cal[43]}}, cal.humid_cal[43:32]};
    assign h5 = {{20{cal.humid_cal[55]}}, cal.humid_cal[55:44]};
    assign h6 = {{24{cal.humid_cal[63]}}, cal.humid_cal[63:56]};

    assign lo      = mul_p[31:0];
    assign hs      = asr32(hv_reg, 15);
    assign rs      = asr64(r_reg, 13);
    assign num_pre = ((64'd1048576 - {44'b0, smp_reg.raw_pressure}) << 31) - v2_reg;
    assign tf_new  = a_reg + asr32(lo, 14);
    assign den_new = asr64(mul_p, 33);

    assign in_ready  = (phase_reg == PH_IDLE);
    assign out_valid = res_valid_reg;
    assign out_word  = res_reg;
    assign mul_start = (phase_reg == PH_MUL) && issue_reg;
    assign div_start = (phase_reg == PH_MUL) && mul_done && (step_reg == STEP_P_NUM);
    assign load_out  = (phase_reg == PH_OUT) && (!res_valid_reg || out_ready);

    always_comb
    begin
        mul_a = 64'd0;
        mul_b = 64'd0;
        case (step_reg)
            STEP_T_A:
            begin
                mul_a = sx32(({12'b0, smp_reg.raw_temperature} >> 3) - (t1 << 1));
                mul_b = sx32(t2);
            end
            STEP_T_SQ:
            begin
                mul_a = sx32(({12'b0, smp_reg.raw_temperature} >> 4) - t1);
                mul_b = mul_a;
            end
            STEP_T_FINE: begin mul_a = sx32(sq32_reg); mul_b = sx32(t3); end
            STEP_H_A:    begin mul_a = sx32(h5);       mul_b = sx32(x_reg); end
            STEP_H_B:    begin mul_a = sx32(x_reg);    mul_b = sx32(h6); end
            STEP_H_C:    begin mul_a = sx32(x_reg);    mul_b = sx32(h3); end
            STEP_H_D:    begin mul_a = sx32(hb_reg);   mul_b = sx32(hc_reg); end
            STEP_H_E:    begin mul_a = sx32(hd_reg);   mul_b = sx32(h2); end
            STEP_H_V:    begin mul_a = sx32(ha_reg);   mul_b = sx32(he_reg); end
            STEP_H_SQ:   begin mul_a = sx32(hs);       mul_b = sx32(hs); end
            STEP_H_FIX:  begin mul_a = sx32(ht_reg);   mul_b = sx32(h1); end
            STEP_P_SQ:   begin mul_a = v1_reg;         mul_b = v1_reg; end
            STEP_P_V2A:  begin mul_a = sq_reg;         mul_b = sx16(cal.press_cal_b[31:16]); end
            STEP_P_V2B:  begin mul_a = v1_reg;         mul_b = sx16(cal.press_cal_b[15:0]); end
            STEP_P_V1A:  begin mul_a = sq_reg;         mul_b = sx16(cal.press_cal_a[47:32]); end
            STEP_P_V1B:  begin mul_a = v1_reg;         mul_b = sx16(cal.press_cal_a[31:16]); end
            STEP_P_DEN:
            begin
                mul_a = (64'd1 << 47) + w_reg;
                mul_b = {48'b0, cal.press_cal_a[15:0]};
            end
            STEP_P_NUM:  begin mul_a = num_pre;        mul_b = 64'd3125; end
            STEP_P_Q1A:  begin mul_a = sx16(cal.press_cal_c); mul_b = rs; end
            STEP_P_Q1B:  begin mul_a = q_reg;          mul_b = rs; end
            STEP_P_Q2:   begin mul_a = sx16(cal.press_cal_b[63:48]); mul_b = r_reg; end
            default:     begin mul_a = 64'd0;          mul_b = 64'd0; end
        endcase
    end

    // Final pressure and humidity clamps.
    assign rfin  = asr64(sum_reg, 8) + (sx16(cal.press_cal_b[47:32]) << 4);
    assign hum32 = hv_reg[31] ? 32'd0 : ((hv_reg > HUM_LIMIT) ? HUM_LIMIT : hv_reg);

    always_comb
    begin
        phase_next     = phase_reg;
        step_next      = step_reg;
        issue_next     = 1'b0;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        if (out_valid && out_ready)
        begin
            res_valid_next = 1'b0;
        end
        case (phase_reg)
            PH_IDLE:
            begin
                if (in_valid)
                begin
                    phase_next = PH_MUL;
                    step_next  = STEP_T_A;
                    issue_next = 1'b1;
                end
            end
            PH_MUL:
            begin
                if (mul_done)
                begin
                    if (step_reg == STEP_P_DEN && den_new == 64'd0)
                    begin
                        phase_next = PH_OUT;
                    end
                    else if (step_reg == STEP_P_NUM)
                    begin
                        phase_next = PH_DIV;
                    end
                    else if (step_reg == STEP_P_Q2)
                    begin
                        phase_next = PH_OUT;
                    end
                    else
                    begin
                        step_next  = step_reg + 5'd1;
                        issue_next = 1'b1;
                    end
                end
            end
            PH_DIV:
            begin
                if (div_done)
                begin
                    phase_next = PH_MUL;
                    step_next  = STEP_P_Q1A;
                    issue_next = 1'b1;
                end
            end
            PH_OUT:
            begin
                if (load_out)
                begin
                    res_valid_next       = 1'b1;
                    res_next.temperature = tf_reg + (tf_reg << 2);
                    res_next.pressure_ok = ok_reg;
                    res_next.humidity    = hum32[28:12];
                    if (!ok_reg || rfin[63])
                    begin
                        res_next.pressure = 32'd0;
                    end
                    else if (rfin[63:32] != 32'd0)
                    begin
                        res_next.pressure = 32'hFFFF_FFFF;
                    end
                    else
                    begin
                        res_next.pressure = rfin[31:0];
                    end
                    phase_next = PH_IDLE;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            step_reg      <= STEP_T_A;
            issue_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            step_reg      <= step_next;
            issue_reg     <= issue_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Datapath write-back, one step per finished product.
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (in_valid && in_ready)
        begin
            smp_reg <= in_word;
        end
        if (div_done)
        begin
            r_reg <= div_q;
        end
        if (mul_done)
        begin
            case (step_reg)
                STEP_T_A:    a_reg    <= asr32(lo, 11);
                STEP_T_SQ:   sq32_reg <= asr32(lo, 12);
                STEP_T_FINE:
                begin
                    tf_reg <= tf_new;
                    x_reg  <= tf_new - 32'd76800;
                    v1_reg <= sx32(tf_new) - 64'd128000;
                end
                STEP_H_A:
                begin
                    ha_reg <= asr32(({16'b0, smp_reg.raw_humidity} << 14) - (h4 << 20)
                                    - lo + 32'd16384, 15);
                end
                STEP_H_B:    hb_reg <= asr32(lo, 10);
                STEP_H_C:    hc_reg <= asr32(lo, 11) + 32'd32768;
                STEP_H_D:    hd_reg <= asr32(lo, 10) + 32'd2097152;
                STEP_H_E:    he_reg <= asr32(lo + 32'd8192, 14);
                STEP_H_V:    hv_reg <= lo;
                STEP_H_SQ:   ht_reg <= asr32(lo, 7);
                STEP_H_FIX:  hv_reg <= hv_reg - asr32(lo, 4);
                STEP_P_SQ:   sq_reg <= mul_p;
                STEP_P_V2A:  v2_reg <= mul_p;
                STEP_P_V2B:
                begin
                    v2_reg <= v2_reg + (mul_p << 17) + (sx16(cal.press_cal_a[63:48]) << 35);
                end
                STEP_P_V1A:  w_reg <= asr64(mul_p, 8);
                STEP_P_V1B:  w_reg <= w_reg + (mul_p << 12);
                STEP_P_DEN:
                begin
                    den_reg <= den_new;
                    ok_reg  <= (den_new != 64'd0);
                end
                STEP_P_Q1A:  q_reg   <= mul_p;
                STEP_P_Q1B:  q1_reg  <= asr64(mul_p, 25);
                STEP_P_Q2:   sum_reg <= r_reg + q1_reg + asr64(mul_p, 19);
                default:     ;
            endcase
        end
    end

    ecomp_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .p     (mul_p)
    );

    ecomp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (mul_p),
        .den   (den_reg),
        .done  (div_done),
        .quo   (div_q)
    );

`ifndef SYNTHESIS
    a_mul_in_mul_phase: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> phase_reg == PH_MUL)
        else $error("product finished outside the multiply phase");

    a_div_in_div_phase: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> phase_reg == PH_DIV)
        else $error("quotient finished outside the divide phase");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_MUL |-> step_reg <= STEP_P_Q2)
        else $error("step counter past the last step");

    a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> res_reg.humidity <= 17'd102400)
        else $error("humidity above one hundred percent");
`endif

endmodule

/* verif/env_sensor_compensation_checker.sv */
// Checker for the sensor compensation block: computes expected results and compares them.
module env_sensor_compensation_checker
    import ecomp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        sample_valid,
    input  logic        sample_ready,
    input  sample_t     sample,
    input  logic        result_valid,
    input  logic        result_ready,
    input  result_t     result,
    input  logic        cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int          mismatches,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    cal_t    cal;
    result_t compensated_q[$];

    function automatic logic [31:0] shr32(input logic [31:0] x, input int n);
        return 32'($signed(x) >>> n);
    endfunction

    function automatic logic [63:0] shr64(input logic [63:0] x, input int n);
        return 64'($signed(x) >>> n);
    endfunction

    function automatic logic [63:0] sdiv64(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] ua;
        logic [63:0] ub;
        logic [63:0] q;
        ua = a[63] ? -a : a;
        ub = b[63] ? -b : b;
        q = ua / ub;
        return (a[63] != b[63]) ? -q : q;
    endfunction

    function automatic result_t compensate(input sample_t s, input cal_t c);
        result_t r;
        logic [31:0] t1, t2, t3, ta, td, tb, tf;
        logic [31:0] h1, h2, h3, h4, h5, h6, x, ha, hb, hc, hd, he, hv, hs, hum;
        logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, v1, v2, q, qs, q1, q2;
        t1 = {16'd0, c.temp_cal[15:0]};
        t2 = {{16{c.temp_cal[31]}}, c.temp_cal[31:16]};
        t3 = {{16{c.temp_cal[47]}}, c.temp_cal[47:32]};
        ta = shr32((({12'd0, s.raw_temperature} >> 3) - (t1 << 1)) * t2, 11);
        td = ({12'd0, s.raw_temperature} >> 4) - t1;
        tb = shr32(shr32(td * td, 12) * t3, 14);
        tf = ta + tb;

        h1 = {24'd0, c.humid_cal[7:0]};
        h2 = {{16{c.humid_cal[23]}}, c.humid_cal[23:8]};
        h3 = {24'd0, c.humid_cal[31:24]};
        h4 = {{20{c.humid_cal[43]}}, c.humid_cal[43:32]};
        h5 = {{20{c.humid_cal[55]}}, c.humid_cal[55:44]};
        h6 = {{24{c.humid_cal[63]}}, c.humid_cal[63:56]};
        x  = tf - 32'd76800;
        ha = shr32(({16'd0, s.raw_humidity} << 14) - (h4 << 20) - h5 * x + 32'd16384, 15);
        hb = shr32(x * h6, 10);
        hc = shr32(x * h3, 11) + 32'd32768;
        hd = shr32(hb * hc, 10) + 32'd2097152;
        he = shr32(hd * h2 + 32'd8192, 14);
        hv = ha * he;
        hs = shr32(hv, 15);
        hv = hv - shr32(shr32(hs * hs, 7) * h1, 4);
        if (hv[31])
            hum = 32'd0;
        else if (hv > 32'd419430400)
            hum = 32'd419430400;
        else
            hum = hv;
        hum = hum >> 12;

        p1 = {48'd0, c.press_cal_a[15:0]};
        p2 = {{48{c.press_cal_a[31]}}, c.press_cal_a[31:16]};
        p3 = {{48{c.press_cal_a[47]}}, c.press_cal_a[47:32]};
        p4 = {{48{c.press_cal_a[63]}}, c.press_cal_a[63:48]};
        p5 = {{48{c.press_cal_b[15]}}, c.press_cal_b[15:0]};
        p6 = {{48{c.press_cal_b[31]}}, c.press_cal_b[31:16]};
        p7 = {{48{c.press_cal_b[47]}}, c.press_cal_b[47:32]};
        p8 = {{48{c.press_cal_b[63]}}, c.press_cal_b[63:48]};
        p9 = {{48{c.press_cal_c[15]}}, c.press_cal_c};
        v1 = {{32{tf[31]}}, tf} - 64'd128000;
        v2 = v1 * v1 * p6;
        v2 = v2 + ((v1 * p5) << 17);
        v2 = v2 + (p4 << 35);
        v1 = shr64(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
        v1 = shr64(((64'd1 << 47) + v1) * p1, 33);

        r.temperature = tf * 32'd5;
        r.humidity    = hum[16:0];
        r.pressure    = '0;
        r.pressure_ok = 1'b0;
        if (v1 != 64'd0)
        begin
            q  = 64'd1048576 - {44'd0, s.raw_pressure};
            q  = sdiv64(((q << 31) - v2) * 64'd3125, v1);
            qs = shr64(q, 13);
            q1 = shr64(p9 * qs * qs, 25);
            q2 = shr64(p8 * q, 19);
            q  = shr64(q + q1 + q2, 8) + (p7 << 4);
            if (q[63])
                r.pressure = '0;
            else if (q > 64'hFFFF_FFFF)
                r.pressure = 32'hFFFF_FFFF;
            else
                r.pressure = q[31:0];
            r.pressure_ok = 1'b1;
        end
        return r;
    endfunction

    assign pending = compensated_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            cal <= '0;
            compensated_q.delete();
            mismatches <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_TEMP_CAL:    cal.temp_cal    <= cfg_data[47:0];
                    CFG_PRESS_CAL_A: cal.press_cal_a <= cfg_data;
                    CFG_PRESS_CAL_B: cal.press_cal_b <= cfg_data;
                    CFG_PRESS_CAL_C: cal.press_cal_c <= cfg_data[15:0];
                    CFG_HUMID_CAL:   cal.humid_cal   <= cfg_data;
                    default: ;
                endcase
            end
            if (sample_valid && sample_ready)
                compensated_q.push_back(compensate(sample, cal));
            if (result_valid && result_ready)
            begin
                if (compensated_q.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected result word %h", result);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = compensated_q.pop_front();
                    if (want !== result)
                    begin
                        if (mismatches < 10)
                            $display("mismatch: temp %h/%h press %h/%h ok %b/%b hum %h/%h",
                                     want.temperature, result.temperature,
                                     want.pressure, result.pressure,
                                     want.pressure_ok, result.pressure_ok,
                                     want.humidity, result.humidity);
                        mismatches <= mismatches + 1;
                    end
                end
            end
        end
    end
endmodule

/* verif/env_sensor_compensation_top_tb.sv */
// Testbench top for the sensor compensation block: stimulus, configuration and verdict.
module env_sensor_compensation_top_tb;
    import ecomp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic sample_valid = 1'b0;
    logic sample_ready;
    sample_t sample = '0;
    logic result_valid;
    logic result_ready = 1'b0;
    result_t result;
    logic cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    int mismatches;
    int pending;
    int cycles = 0;
    bit long_hold = 1'b0;   // asks the receiver to stall for a long stretch
    bit gaps_on = 1'b1;     // random gaps between bursts of words

    localparam int CYCLE_LIMIT = 1_500_000;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    env_sensor_compensation_top dut (.*);

    env_sensor_compensation_checker checker_i (.*);

    // Watchdog: ends the run with an error past CYCLE_LIMIT, which is several
    // times the slowest expected run of about 500 words.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[env_sensor_compensation_top] ERROR");
            $finish;
        end
    end

    // The receiver stalls on a pattern of its own: some stretches always
    // ready, some with random stalls, and one long hold when requested.
    initial
    begin
        int mode;
        int span;
        @(posedge rst_n);
        forever
        begin
            if (long_hold)
            begin
                repeat (3000)
                begin
                    @(posedge clk);
                    result_ready <= 1'b0;
                end
                long_hold = 1'b0;
            end
            mode = $urandom_range(0, 2);
            span = $urandom_range(50, 800);
            repeat (span)
            begin
                @(posedge clk);
                case (mode)
                    0: result_ready <= 1'b1;
                    1: result_ready <= ($urandom_range(0, 3) != 0);
                    default: result_ready <= ($urandom_range(0, 9) < 3);
                endcase
            end
        end
    end

    // Offer one word and hold it until the block takes it; valid stays high
    // so that the next word can follow without a gap.
    task automatic send_word(input sample_t s);
        sample_valid <= 1'b1;
        sample <= s;
        @(posedge clk);
        while (!sample_ready)
            @(posedge clk);
    endtask

    // Sender bursts: after each word, sometimes leave a random gap.
    task automatic send_paced(input sample_t s);
        send_word(s);
        if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            sample_valid <= 1'b0;
            repeat ($urandom_range(1, 300)) @(posedge clk);
        end
    endtask

    // Write enable stays high so that writes can follow back to back; the
    // caller drops it after the last write of a group.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] d);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        @(posedge clk);
    endtask

    // Waits until every expected word has come back, plus the engine latency.
    task automatic drain;
        sample_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    function automatic logic [63:0] rand64;
        return {$urandom(), $urandom()};
    endfunction

    function automatic sample_t rand_sample;
        sample_t s;
        s.raw_temperature = 20'($urandom());
        s.raw_pressure = 20'($urandom());
        s.raw_humidity = 16'($urandom());
        case ($urandom_range(0, 7))
            0: s.raw_temperature = $urandom_range(0, 1) ? '1 : '0;
            1: s.raw_pressure = $urandom_range(0, 1) ? '1 : '0;
            2: s.raw_humidity = $urandom_range(0, 1) ? '1 : '0;
            default: ;
        endcase
        return s;
    endfunction

    // Calibration close to a typical factory set, so that results stay in
    // their useful ranges; the random bits keep exploring around it.
    task automatic load_typical;
        write_reg(CFG_TEMP_CAL, {16'($signed(-16'd1000) + $urandom_range(0, 63)),
                                 16'(26000 + $urandom_range(0, 2000)),
                                 16'(27000 + $urandom_range(0, 2000))});
        write_reg(CFG_PRESS_CAL_A, {16'(3000 + $urandom_range(0, 9000)),
                                    16'(3000 + $urandom_range(0, 2000)),
                                    16'(-10500 - $urandom_range(0, 500)),
                                    16'(35000 + $urandom_range(0, 3000))});
        write_reg(CFG_PRESS_CAL_B, {16'(3000 + $urandom_range(0, 2000)),
                                    16'(-15000 + $urandom_range(0, 3000)),
                                    16'(-20 + $urandom_range(0, 40)),
                                    16'(100 + $urandom_range(0, 300))});
        write_reg(CFG_PRESS_CAL_C, 64'(6000 + $urandom_range(0, 1000)));
        write_reg(CFG_HUMID_CAL, {8'(30), 12'(50), 12'(330 + $urandom_range(0, 20)),
                                  8'(0), 16'(360 + $urandom_range(0, 20)), 8'(75)});
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        sample_t s;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset calibration: divisor is zero, so pressure is flagged invalid.
        send_word('0);
        send_word('1);
        drain();

        // Typical calibration with the extremes of every raw field.
        load_typical();
        send_word('{20'd0, 20'd0, 16'd0});
        send_word('{20'hFFFFF, 20'hFFFFF, 16'hFFFF});
        send_word('{20'd519888, 20'd415148, 16'd27000});
        send_word('{20'd0, 20'hFFFFF, 16'd0});
        send_word('{20'hFFFFF, 20'd0, 16'hFFFF});
        send_word('{20'd600000, 20'd200000, 16'd60000});
        send_word('{20'd400000, 20'd600000, 16'd10000});
        drain();

        // Extreme calibration words: all ones, then sign bits only, with the unsigned fields all ones.
        write_reg(CFG_TEMP_CAL, '1);
        write_reg(CFG_PRESS_CAL_A, '1);
        write_reg(CFG_PRESS_CAL_B, '1);
        write_reg(CFG_PRESS_CAL_C, '1);
        write_reg(CFG_HUMID_CAL, '1);
        write_reg(3'd7, rand64());  // index past the list is ignored
        cfg_we <= 1'b0;
        send_word('0);
        send_word('1);
        send_word('{20'd519888, 20'd415148, 16'd27000});
        drain();
        write_reg(CFG_TEMP_CAL, 64'h8000_8000_FFFF);
        write_reg(CFG_PRESS_CAL_A, 64'h8000_8000_8000_FFFF);
        write_reg(CFG_PRESS_CAL_B, 64'h8000_8000_8000_8000);
        write_reg(CFG_PRESS_CAL_C, 64'h8000);
        write_reg(CFG_HUMID_CAL, 64'h8080_0800_FF80_00FF);
        cfg_we <= 1'b0;
        send_word('0);
        send_word('1);
        send_word('{20'd519888, 20'd415148, 16'd27000});
        drain();

        // Random phases: mostly typical calibration, some fully random.
        for (int ph = 0; ph < 9; ph++)
        begin
            if (ph % 3 == 2)
            begin
                write_reg(CFG_TEMP_CAL, rand64());
                write_reg(CFG_PRESS_CAL_A, rand64());
                write_reg(CFG_PRESS_CAL_B, rand64());
                write_reg(CFG_PRESS_CAL_C, rand64());
                write_reg(CFG_HUMID_CAL, rand64());
                cfg_we <= 1'b0;
            end
            else
                load_typical();
            if (ph == 4)
            begin
                // Receiver holds off while the sender keeps offering words,
                // so the queue fills and sample_ready drops.
                long_hold = 1'b1;
                gaps_on = 1'b0;
            end
            for (int i = 0; i < 48; i++)
            begin
                s = rand_sample();
                send_paced(s);
            end
            gaps_on = 1'b1;
            // Sender pauses until every expected word has come back.
            drain();
        end

        if (mismatches == 0)
            $display("[env_sensor_compensation_top] OK");
        else
            $display("[env_sensor_compensation_top] ERROR");
        $finish;
    end
endmodule

/* filelist.f */
rtl/ecomp_pkg.sv
rtl/ecomp_front.sv
rtl/ecomp_mul.sv
rtl/ecomp_div.sv
rtl/ecomp_core.sv
rtl/env_sensor_compensation_top.sv
verif/env_sensor_compensation_checker.sv
verif/env_sensor_compensation_top_tb.sv
